// ===== sv/byte_deque_with_palindrome_check_top_defines.svh =====
// ----------------------------------------------------------------------------
// Byte deque assertion macros
// Concurrent assertion wrappers for the byte deque; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef BYTE_DEQUE_WITH_PALINDROME_CHECK_TOP_DEFINES_SVH
`define BYTE_DEQUE_WITH_PALINDROME_CHECK_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// condition must hold at every edge out of reset
`define BDQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define BDQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BDQ_ASSERT(lbl, clk, rst, prop, msg)
`define BDQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== sv/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// Byte deque package
// Field widths, request and status codes, control states and the result type.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int REQ_W    = 3;
  localparam int BYTE_W   = 8;
  localparam int FILL_W   = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_REAR  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_REAR   = 3'd3,
    REQ_CHECK      = 3'd4
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_CHECK
  } state_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   popped_value;
    logic [BYTE_W-1:0]   front_value;
    logic [BYTE_W-1:0]   rear_value;
    logic [FILL_W-1:0]   fill_count;
    logic [STATUS_W-1:0] status;
    logic                is_palindrome;
  } res_t;

endpackage

// ===== sv/bdq_ifs.sv =====
// ----------------------------------------------------------------------------
// Byte deque channels
// Valid/ready request and result channels of the byte deque.
// ----------------------------------------------------------------------------
interface bdq_req_if;
  logic                          valid;
  logic                          ready;
  logic [bdq_pkg::REQ_W-1:0]     req_type;
  logic [bdq_pkg::BYTE_W-1:0]    push_value;

  modport source (output valid, req_type, push_value, input ready);
  modport sink   (input valid, req_type, push_value, output ready);
endinterface

interface bdq_res_if;
  logic                          valid;
  logic                          ready;
  logic [bdq_pkg::BYTE_W-1:0]    popped_value;
  logic [bdq_pkg::BYTE_W-1:0]    front_value;
  logic [bdq_pkg::BYTE_W-1:0]    rear_value;
  logic [bdq_pkg::FILL_W-1:0]    fill_count;
  logic [bdq_pkg::STATUS_W-1:0]  status;
  logic                          is_palindrome;

  modport source (output valid, popped_value, front_value, rear_value, fill_count,
                  status, is_palindrome, input ready);
  modport sink   (input valid, popped_value, front_value, rear_value, fill_count,
                  status, is_palindrome, output ready);
endinterface

// ===== sv/byte_deque_with_palindrome_check_top.sv =====
// ----------------------------------------------------------------------------
// Byte deque with palindrome check
// Bounded double-ended byte queue in a ring memory, with a mirrored-pair check.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                    | one item
//  --------+-----+--------------------------------------------+-------------------
//  req     | in  | req_type, push_value                       | one request
//  res     | out | popped_value, front_value, rear_value,     | one result per req
//          |     | fill_count, status, is_palindrome          |
//
//  Push, failed pop/push, unknown code, short check: finished without leaving
//  IDLE. Pop that leaves the deque non-empty: passes through POP (read of the
//  new end entry through the registered memory port).
//  Check on N >= 2 bytes: walks up to N/2 mirrored pairs in CHECK, one mirrored
//  pair per cycle over the two read ports; stops early on the first mismatch.
//  Reset clears state, pointers, count and the valid flags; the ring memory is
//  not cleared. A finished result parks in a hold register while res stalls;
//  req is open only in IDLE with that register empty.
// ----------------------------------------------------------------------------
`include "byte_deque_with_palindrome_check_top_defines.svh"

module byte_deque_with_palindrome_check_top #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  bdq_req_if.sink       req,
  bdq_res_if.source     res
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // ring index
  localparam int CW = $clog2(DEPTH + 1);                // fill count
  localparam int PW = $clog2(DEPTH / 2 + 1);            // pairs still to compare
  localparam int BW = bdq_pkg::BYTE_W;

  // ring index step with wrap; DEPTH need not be a power of two
  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
    return (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
  endfunction

  // control state
  bdq_pkg::state_t state, state_next;
  logic [AW-1:0]   head, head_next;        // front entry
  logic [AW-1:0]   tail, tail_next;        // rear entry, meaningful when count != 0
  logic [CW-1:0]   count, count_next;

  // cached end bytes, so pushes need no memory read
  logic [BW-1:0]   front_byte, front_byte_next;
  logic [BW-1:0]   rear_byte, rear_byte_next;

  // pop in flight
  logic            pop_front, pop_front_next;
  logic [BW-1:0]   popped, popped_next;

  // mirror walk
  logic [AW-1:0]   lo, lo_next;
  logic [AW-1:0]   hi, hi_next;
  logic [PW-1:0]   pairs_left, pairs_left_next;

  // ring memory
  logic [BW-1:0]   mem [DEPTH];
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [BW-1:0]   wr_data;
  logic [AW-1:0]   rd_addr_a, rd_addr_b;
  logic [BW-1:0]   rd_a, rd_b;

  // result path
  logic            accept;
  logic            done;
  bdq_pkg::res_t   done_res;
  logic            out_valid;
  bdq_pkg::res_t   out_res;
  logic            hold_valid;
  bdq_pkg::res_t   hold_res;
  logic            out_free;

  logic            full, empty;
  logic            pair_miss, pair_last;

  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign pair_miss = (rd_a != rd_b);
  assign pair_last = (pairs_left == PW'(1));

  assign req.ready = (state == bdq_pkg::S_IDLE) && !hold_valid;
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || res.ready;

  // ---------------------------------------------------------------------------
  // Next state: only non-trivial pops and checks leave IDLE
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      bdq_pkg::S_IDLE: begin
        if (accept) begin
          if ((req.req_type == bdq_pkg::REQ_POP_FRONT ||
               req.req_type == bdq_pkg::REQ_POP_REAR) && count >= CW'(2)) begin
            state_next = bdq_pkg::S_POP;
          end else if (req.req_type == bdq_pkg::REQ_CHECK && count >= CW'(2)) begin
            state_next = bdq_pkg::S_CHECK;
          end
        end
      end
      bdq_pkg::S_POP: begin
        state_next = bdq_pkg::S_IDLE;
      end
      bdq_pkg::S_CHECK: begin
        if (pair_miss || pair_last) begin
          state_next = bdq_pkg::S_IDLE;
        end
      end
      default: state_next = bdq_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and result
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [BW-1:0] res_popped;
    logic [1:0]    res_status;
    logic          res_pal;
    logic [AW-1:0] slot;

    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    front_byte_next = front_byte;
    rear_byte_next  = rear_byte;
    pop_front_next  = pop_front;
    popped_next     = popped;
    lo_next         = lo;
    hi_next         = hi;
    pairs_left_next = pairs_left;
    wr_en           = 1'b0;
    wr_addr         = head;
    wr_data         = req.push_value;
    rd_addr_a       = head;
    rd_addr_b       = tail;
    done            = 1'b0;
    res_popped      = '0;
    res_status      = bdq_pkg::ST_OK;
    res_pal         = 1'b0;
    slot            = head;

    unique case (state)
      bdq_pkg::S_IDLE: begin
        if (accept) begin
          case (req.req_type)
            bdq_pkg::REQ_PUSH_FRONT: begin
              done = 1'b1;
              if (full) begin
                res_status = bdq_pkg::ST_FULL;
              end else begin
                slot            = idx_dec(head);
                wr_en           = 1'b1;
                wr_addr         = slot;
                head_next       = slot;
                front_byte_next = req.push_value;
                count_next      = count + CW'(1);
                if (empty) begin
                  tail_next      = slot;
                  rear_byte_next = req.push_value;
                end
              end
            end
            bdq_pkg::REQ_PUSH_REAR: begin
              done = 1'b1;
              if (full) begin
                res_status = bdq_pkg::ST_FULL;
              end else begin
                slot           = empty ? head : idx_inc(tail);
                wr_en          = 1'b1;
                wr_addr        = slot;
                tail_next      = slot;
                rear_byte_next = req.push_value;
                count_next     = count + CW'(1);
                if (empty) begin
                  front_byte_next = req.push_value;
                end
              end
            end
            bdq_pkg::REQ_POP_FRONT: begin
              if (empty) begin
                done       = 1'b1;
                res_status = bdq_pkg::ST_EMPTY;
              end else begin
                res_popped     = front_byte;
                popped_next    = front_byte;
                pop_front_next = 1'b1;
                head_next      = idx_inc(head);
                count_next     = count - CW'(1);
                rd_addr_a      = idx_inc(head);
                done           = (count == CW'(1));
              end
            end
            bdq_pkg::REQ_POP_REAR: begin
              if (empty) begin
                done       = 1'b1;
                res_status = bdq_pkg::ST_EMPTY;
              end else begin
                res_popped     = rear_byte;
                popped_next    = rear_byte;
                pop_front_next = 1'b0;
                tail_next      = idx_dec(tail);
                count_next     = count - CW'(1);
                rd_addr_a      = idx_dec(tail);
                done           = (count == CW'(1));
              end
            end
            bdq_pkg::REQ_CHECK: begin
              // first pair is read in this cycle
              lo_next         = head;
              hi_next         = tail;
              pairs_left_next = PW'(count >> 1);
              if (count < CW'(2)) begin
                done    = 1'b1;
                res_pal = 1'b1;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      bdq_pkg::S_POP: begin
        done       = 1'b1;
        res_popped = popped;
        if (pop_front) begin
          front_byte_next = rd_a;
        end else begin
          rear_byte_next = rd_a;
        end
      end
      bdq_pkg::S_CHECK: begin
        if (pair_miss) begin
          done = 1'b1;
        end else if (pair_last) begin
          done    = 1'b1;
          res_pal = 1'b1;
        end else begin
          lo_next         = idx_inc(lo);
          hi_next         = idx_dec(hi);
          pairs_left_next = pairs_left - PW'(1);
          rd_addr_a       = idx_inc(lo);
          rd_addr_b       = idx_dec(hi);
        end
      end
      default: begin
      end
    endcase

    done_res.popped_value  = res_popped;
    done_res.front_value   = (count_next != '0) ? front_byte_next : '0;
    done_res.rear_value    = (count_next != '0) ? rear_byte_next : '0;
    done_res.fill_count    = bdq_pkg::FILL_W'(count_next);
    done_res.status        = res_status;
    done_res.is_palindrome = res_pal;
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdq_pkg::S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    front_byte <= front_byte_next;
    rear_byte  <= rear_byte_next;
    pop_front  <= pop_front_next;
    popped     <= popped_next;
    lo         <= lo_next;
    hi         <= hi_next;
    pairs_left <= pairs_left_next;
  end

  // ring memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[rd_addr_a];
    rd_b <= mem[rd_addr_b];
  end

  // output register plus hold slot; a held result always drains first
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (hold_valid) begin
        if (out_free) begin
          out_valid  <= 1'b1;
          hold_valid <= 1'b0;
        end
      end else if (done) begin
        if (out_free) begin
          out_valid <= 1'b1;
        end else begin
          hold_valid <= 1'b1;
        end
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hold_valid) begin
      if (out_free) begin
        out_res <= hold_res;
      end
    end else if (done) begin
      if (out_free) begin
        out_res <= done_res;
      end else begin
        hold_res <= done_res;
      end
    end
  end

  assign res.valid         = out_valid;
  assign res.popped_value  = out_res.popped_value;
  assign res.front_value   = out_res.front_value;
  assign res.rear_value    = out_res.rear_value;
  assign res.fill_count    = out_res.fill_count;
  assign res.status        = out_res.status;
  assign res.is_palindrome = out_res.is_palindrome;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `BDQ_ASSERT(a_count_bound, clk, rst, count <= CW'(DEPTH), "fill count beyond depth")
  `BDQ_ASSERT(a_hold_behind_out, clk, rst, !hold_valid || out_valid, "hold used with free out")
  `BDQ_ASSERT(a_hold_idle, clk, rst, !hold_valid || state == bdq_pkg::S_IDLE, "item in flight while result held")
  `BDQ_ASSERT_NEXT(a_push_grows, clk, rst, accept && !full && (req.req_type == bdq_pkg::REQ_PUSH_FRONT || req.req_type == bdq_pkg::REQ_PUSH_REAR), count == $past(count) + CW'(1), "push did not grow count")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Byte deque with palindrome check: testbench
// Drives requests through the valid/ready request channel and tracks the
// deque's contents in a local ring copy. Each accepted request yields one
// reply, which is compared field by field against the local copy's view.
// Directed edge cases come first. After them: fill/drain rounds, built
// palindromes with optional corruption, a long result stall and
// push-/pop-biased random traffic.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEPTH       = bdq_pkg::DEPTH_DEF;
  localparam int REQ_W       = bdq_pkg::REQ_W;
  localparam int BYTE_W      = bdq_pkg::BYTE_W;
  localparam int FILL_W      = bdq_pkg::FILL_W;
  localparam int CYCLE_LIMIT = 2000000;
  // longest check walks DEPTH/2 pairs plus the hold register; pad generously
  localparam int TAIL_CYCLES = DEPTH + 8;
  localparam int SHOW_LIMIT  = 10;

  // request codes outside the enum, which the block must ignore
  localparam logic [REQ_W-1:0] REQ_RSVD_FIRST = 3'd5;
  localparam logic [REQ_W-1:0] REQ_RSVD_LAST  = 3'd7;

  logic clk;
  logic rst;

  bdq_req_if req_ch ();
  bdq_res_if res_ch ();

  byte_deque_with_palindrome_check_top #(.DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  // Local copy of the deque: ring contents, front index, fill level.
  logic [BYTE_W-1:0] deque_mem [DEPTH];
  int                deque_head;
  int                deque_fill;

  // Replies owed by the block, oldest first.
  bdq_pkg::res_t deque_replies_due [$];

  int mismatch_count;
  int reply_count;
  int cycle_count;

  // Idle control: quiet means no gaps on that side.
  bit tx_quiet;
  bit rx_quiet;
  int rx_hold_cycles;  // long result stall, counted down by the receiver
  int rx_stall_left;

  // --------------------------------------------------------------------------
  // Clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Deque behavior
  // --------------------------------------------------------------------------
  function automatic int ring_slot(int offset);
    return (deque_head + offset) % DEPTH;
  endfunction

  // count/2 mirrored pairs; empty and single-byte contents count as a match
  function automatic logic mirror_matches();
    int k;
    for (k = 0; k < deque_fill / 2; k++) begin
      if (deque_mem[ring_slot(k)] !== deque_mem[ring_slot(deque_fill - 1 - k)])
        return 1'b0;
    end
    return 1'b1;
  endfunction

  // Apply one request to the local copy and return the reply it must produce.
  function automatic bdq_pkg::res_t deque_apply(logic [REQ_W-1:0] kind,
                                                logic [BYTE_W-1:0] val);
    bdq_pkg::res_t r;
    r = '0;
    r.status = bdq_pkg::ST_OK;
    case (kind)
      bdq_pkg::REQ_PUSH_FRONT: begin
        if (deque_fill >= DEPTH) begin
          r.status = bdq_pkg::ST_FULL;
        end else begin
          deque_head = (deque_head + DEPTH - 1) % DEPTH;
          deque_mem[deque_head] = val;
          deque_fill++;
        end
      end
      bdq_pkg::REQ_PUSH_REAR: begin
        if (deque_fill >= DEPTH) begin
          r.status = bdq_pkg::ST_FULL;
        end else begin
          deque_mem[ring_slot(deque_fill)] = val;
          deque_fill++;
        end
      end
      bdq_pkg::REQ_POP_FRONT: begin
        if (deque_fill == 0) begin
          r.status = bdq_pkg::ST_EMPTY;
        end else begin
          r.popped_value = deque_mem[deque_head];
          deque_head = ring_slot(1);
          deque_fill--;
        end
      end
      bdq_pkg::REQ_POP_REAR: begin
        if (deque_fill == 0) begin
          r.status = bdq_pkg::ST_EMPTY;
        end else begin
          r.popped_value = deque_mem[ring_slot(deque_fill - 1)];
          deque_fill--;
        end
      end
      bdq_pkg::REQ_CHECK: begin
        r.is_palindrome = mirror_matches();
      end
      default: ;  // reserved codes leave everything alone
    endcase
    if (deque_fill != 0) begin
      r.front_value = deque_mem[deque_head];
      r.rear_value  = deque_mem[ring_slot(deque_fill - 1)];
    end
    r.fill_count = FILL_W'(deque_fill);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Reply checking: requests update the local copy at acceptance, replies
  // are matched in order. Both handled here so same-edge ordering is fixed.
  // --------------------------------------------------------------------------
  task automatic compare_field(string field, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= SHOW_LIMIT)
        $display("reply %0d: %s expected %0h, got %0h", reply_count, field, want, got);
    end
  endtask

  always @(posedge clk) begin : reply_monitor
    bdq_pkg::res_t seen;
    bdq_pkg::res_t due;
    if (!rst) begin
      if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
        deque_replies_due.push_back(deque_apply(req_ch.req_type, req_ch.push_value));
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        seen.popped_value  = res_ch.popped_value;
        seen.front_value   = res_ch.front_value;
        seen.rear_value    = res_ch.rear_value;
        seen.fill_count    = res_ch.fill_count;
        seen.status        = res_ch.status;
        seen.is_palindrome = res_ch.is_palindrome;
        if (deque_replies_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= SHOW_LIMIT)
            $display("reply %0d: arrived with no request outstanding", reply_count);
        end else begin
          due = deque_replies_due.pop_front();
          compare_field("popped_value", due.popped_value, seen.popped_value);
          compare_field("front_value", due.front_value, seen.front_value);
          compare_field("rear_value", due.rear_value, seen.rear_value);
          compare_field("fill_count", BYTE_W'(due.fill_count), BYTE_W'(seen.fill_count));
          compare_field("status", BYTE_W'(due.status), BYTE_W'(seen.status));
          compare_field("is_palindrome", BYTE_W'(due.is_palindrome),
                        BYTE_W'(seen.is_palindrome));
        end
        reply_count++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Idle gaps: mostly none or short, now and then long.
  // --------------------------------------------------------------------------
  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 85)
      return $urandom_range(1, 2);
    if (r < 97)
      return $urandom_range(3, 8);
    return $urandom_range(12, 40);
  endfunction

  // Result side: one ready decision per edge. A requested long hold wins
  // over the random stalls.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        res_ch.ready <= 1'b0;
        rx_hold_cycles--;
      end else if (rx_stall_left > 0) begin
        res_ch.ready <= 1'b0;
        rx_stall_left--;
      end else begin
        res_ch.ready <= 1'b1;
        if ($urandom_range(0, 9) < 3)
          rx_stall_left = pick_gap(rx_quiet);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Offer one item and return at the edge where it is taken. valid stays up
  // so a back-to-back call keeps the channel busy.
  task automatic send_request(logic [REQ_W-1:0] kind, logic [BYTE_W-1:0] val);
    int gap;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.push_value <= val;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
  endtask

  // Drop valid and wait until every owed reply has come back.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (deque_replies_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [REQ_W-1:0] any_push();
    return $urandom_range(0, 1) ? bdq_pkg::REQ_PUSH_REAR : bdq_pkg::REQ_PUSH_FRONT;
  endfunction

  function automatic logic [REQ_W-1:0] any_pop();
    return $urandom_range(0, 1) ? bdq_pkg::REQ_POP_REAR : bdq_pkg::REQ_POP_FRONT;
  endfunction

  function automatic logic [BYTE_W-1:0] any_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // Empty the deque; level is read from the local copy once quiescent.
  task automatic drain_deque();
    int k;
    int n;
    wait_idle();
    n = deque_fill;
    for (k = 0; k < n; k++)
      send_request(any_pop(), any_byte());
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Starts right after reset with an empty deque.
  task automatic test_directed_edges();
    logic [REQ_W-1:0] code;
    send_request(bdq_pkg::REQ_POP_FRONT, 8'h00);   // pop on empty, both ends
    send_request(bdq_pkg::REQ_POP_REAR, 8'hFF);
    send_request(bdq_pkg::REQ_CHECK, 8'h00);       // empty reads as a palindrome
    send_request(bdq_pkg::REQ_PUSH_REAR, 8'h00);
    send_request(bdq_pkg::REQ_CHECK, 8'hFF);       // single byte
    send_request(bdq_pkg::REQ_PUSH_FRONT, 8'hFF);
    send_request(bdq_pkg::REQ_CHECK, 8'h00);       // two bytes, mismatched
    send_request(bdq_pkg::REQ_POP_REAR, 8'h00);
    send_request(bdq_pkg::REQ_POP_FRONT, 8'h00);   // last byte out, ends read zero
    for (code = REQ_RSVD_FIRST; code != REQ_RSVD_LAST; code++)
      send_request(code, 8'hA5);
    send_request(REQ_RSVD_LAST, 8'h5A);
    send_request(bdq_pkg::REQ_PUSH_FRONT, 8'h81);
    send_request(REQ_RSVD_FIRST, 8'hFF);           // ignored with data present
    send_request(bdq_pkg::REQ_PUSH_REAR, 8'h81);
    send_request(bdq_pkg::REQ_CHECK, 8'h7E);       // two bytes, matched
    send_request(bdq_pkg::REQ_POP_FRONT, 8'h00);
    send_request(bdq_pkg::REQ_POP_REAR, 8'h00);
  endtask

  // Full and empty boundaries with random content.
  task automatic test_fill_and_drain(int rounds);
    int r;
    int k;
    drain_deque();
    for (r = 0; r < rounds; r++) begin
      tx_quiet = (r % 2 == 1);
      for (k = 0; k < DEPTH; k++)
        send_request(any_push(), any_byte());
      for (k = 0; k < 3; k++)
        send_request(any_push(), any_byte());  // dropped, flagged full
      send_request(bdq_pkg::REQ_CHECK, any_byte());
      for (k = 0; k < DEPTH; k++)
        send_request(any_pop(), any_byte());
      send_request(bdq_pkg::REQ_POP_FRONT, any_byte());
      send_request(bdq_pkg::REQ_POP_REAR, any_byte());
    end
    tx_quiet = 1'b0;
  endtask

  // Build palindromes from a random split point outward, sometimes with one
  // byte changed, check them, then take them apart from random ends.
  task automatic test_mirror_sequences(int n_seq);
    logic [BYTE_W-1:0] seq [DEPTH];
    int s;
    int k;
    int len;
    int lo;
    int hi;
    int alpha;
    drain_deque();
    for (s = 0; s < n_seq; s++) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      len   = ($urandom_range(0, 3) == 0) ? DEPTH : $urandom_range(0, DEPTH - 1);
      alpha = $urandom_range(0, 1) ? 255 : 3;  // small alphabet gives near misses
      for (k = 0; k < len; k++)
        seq[k] = BYTE_W'($urandom_range(0, alpha));
      for (k = 0; k < len / 2; k++)
        seq[len - 1 - k] = seq[k];
      if (len > 0 && $urandom_range(0, 2) == 0) begin
        k = $urandom_range(0, len - 1);
        seq[k] = BYTE_W'($urandom_range(0, alpha));
      end
      hi = $urandom_range(0, len);
      lo = hi - 1;
      while (lo >= 0 || hi < len) begin
        if (lo >= 0 && (hi >= len || $urandom_range(0, 1) == 1)) begin
          send_request(bdq_pkg::REQ_PUSH_FRONT, seq[lo]);
          lo--;
        end else begin
          send_request(bdq_pkg::REQ_PUSH_REAR, seq[hi]);
          hi++;
        end
        if ($urandom_range(0, 7) == 0)
          send_request(bdq_pkg::REQ_CHECK, any_byte());
      end
      send_request(bdq_pkg::REQ_CHECK, any_byte());
      if (len == DEPTH && $urandom_range(0, 1) == 1)
        send_request(any_push(), any_byte());
      for (k = 0; k < len; k++) begin
        send_request(any_pop(), any_byte());
        if ($urandom_range(0, 4) == 0)
          send_request(bdq_pkg::REQ_CHECK, any_byte());
      end
      if ($urandom_range(0, 2) == 0)
        send_request(any_pop(), any_byte());
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // Result side holds off for a long stretch while requests keep coming,
  // so the hold register fills and the request channel must stall.
  task automatic test_result_backpressure();
    int k;
    int r;
    tx_quiet = 1'b1;
    rx_hold_cycles = 150;
    for (k = 0; k < 40; k++) begin
      r = $urandom_range(0, 9);
      if (r < 5)
        send_request(any_push(), any_byte());
      else if (r < 8)
        send_request(any_pop(), any_byte());
      else
        send_request(bdq_pkg::REQ_CHECK, any_byte());
    end
    tx_quiet = 1'b0;
  endtask

  // Mixed traffic in epochs, each with a push/pop bias, byte alphabet and
  // idle setting of its own; push-heavy epochs run into full, pop-heavy
  // ones into empty.
  task automatic test_random_traffic(int n_items);
    int i;
    int r;
    int bias;
    int alpha;
    logic [REQ_W-1:0] kind;
    bias  = 50;
    alpha = 255;
    for (i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        r = $urandom_range(0, 2);
        bias     = (r == 0) ? 15 : (r == 1) ? 50 : 85;
        alpha    = $urandom_range(0, 1) ? 255 : 1;
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 3)
        kind = REQ_W'($urandom_range(REQ_RSVD_FIRST, REQ_RSVD_LAST));
      else if (r < 13)
        kind = bdq_pkg::REQ_CHECK;
      else if ($urandom_range(0, 99) < bias)
        kind = any_push();
      else
        kind = any_pop();
      send_request(kind, BYTE_W'($urandom_range(0, alpha)));
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence of tests
  // --------------------------------------------------------------------------
  initial begin
    deque_head     = 0;
    deque_fill     = 0;
    mismatch_count = 0;
    reply_count    = 0;
    cycle_count    = 0;
    tx_quiet       = 1'b0;
    rx_quiet       = 1'b0;
    rx_hold_cycles = 0;
    rx_stall_left  = 0;
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= bdq_pkg::REQ_PUSH_FRONT;
    req_ch.push_value <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_edges();
    test_fill_and_drain(2);
    test_mirror_sequences(40);
    test_result_backpressure();
    test_random_traffic(700);
    test_mirror_sequences(10);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && deque_replies_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
